// ===== rtl/core/two_level_cache_lookup_top_defines.svh =====
// Assertion macros shared by the cache lookup RTL
`ifndef TWO_LEVEL_CACHE_LOOKUP_TOP_DEFINES_SVH
`define TWO_LEVEL_CACHE_LOOKUP_TOP_DEFINES_SVH
// Implication checked on every clock edge outside reset
`define TLC_ASSERT_IMP(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);
// Next-cycle implication checked outside reset
`define TLC_ASSERT_NXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);
`endif

// ===== rtl/core/tlc_pkg.sv =====
package tlc_pkg;
	localparam int L1Ways = 4;
	localparam int L1Sets = 128;
	localparam int L1SetBits = 7;
	localparam int L1TagBits = 51;
	localparam int L2Ways = 8;
	localparam int L2Sets = 2048;
	localparam int L2SetBits = 11;
	localparam int L2TagBits = 47;
	localparam int OffBits = 6;

	localparam logic [1:0] REG_L1_LAT = 2'd0;
	localparam logic [1:0] REG_L2_LAT = 2'd1;
	localparam logic [1:0] REG_MEM_LAT = 2'd2;

	localparam logic FUNC_WRITE = 1'b0;
	localparam logic FUNC_READ = 1'b1;

	typedef struct packed {
		logic [31:0] stamp;
		logic        func;
		logic [63:0] address;
	} req_t;

	typedef struct packed {
		logic        l1_hit;
		logic        l2_accessed;
		logic        l2_hit;
		logic [12:0] access_latency;
		logic        l1_dirty_evict;
		logic        l2_dirty_evict;
		logic [31:0] latency_total;
		logic [31:0] reference_count;
		logic [31:0] l1_hit_count;
		logic [31:0] l2_reference_count;
		logic [31:0] l2_hit_count;
	} rsp_t;

	// One way entry: valid, dirty, last-use stamp, tag
	typedef struct packed {
		logic                 v;
		logic                 d;
		logic [31:0]          use_stamp;
		logic [L1TagBits-1:0] tag;
	} l1_line_t;

	typedef struct packed {
		logic                 v;
		logic                 d;
		logic [31:0]          use_stamp;
		logic [L2TagBits-1:0] tag;
	} l2_line_t;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_L1,
		ST_L2,
		ST_OUT
	} state_t;
endpackage

// ===== rtl/core/two_level_cache_lookup_top.sv =====
// Two-level cache lookup: one memory access in, one result out.
// Input channel in_valid/in_ready carries stamp, func (0 write, 1 read) and
// a 64-bit byte address. Output channel out_valid/out_ready returns hit
// flags, the access latency, dirty eviction flags and running totals.
// Config channel cfg_valid/cfg_ready writes l1_hit_latency (index 0),
// l2_hit_latency (1) and memory_latency (2); other indexes are ignored.
// Both tag stores are single-port synchronous RAMs holding a whole set per
// row. An item on an L1 hit passes through accept, L1 set read and L1 update;
// an L1 miss adds the L2 set read. One item is in flight at a time.
// After reset a clearing pass walks all 2048 sets of the L2 RAM, one set per
// cycle (the L1 RAM is cleared in the same pass during its first 128 sets);
// no item is accepted until it finishes. Config is always taken.
// The result sits in an output register; when the receiver stalls, the
// block holds it and accepts the next item only after the transfer.
module two_level_cache_lookup_top (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_ready,
	input  tlc_pkg::req_t  in_data,
	output logic           out_valid,
	input  logic           out_ready,
	output tlc_pkg::rsp_t  out_data,
	input  logic           cfg_valid,
	output logic           cfg_ready,
	input  logic [1:0]     cfg_index,
	input  logic [31:0]    cfg_data
);
	import tlc_pkg::*;
`include "two_level_cache_lookup_top_defines.svh"

	state_t state_q, state_d;
	logic [L2SetBits-1:0] clr_q;
	req_t req_q;
	logic [9:0] l1_lat_q, l2_lat_q;
	logic [11:0] mem_lat_q;
	logic [31:0] sum_q, refs_q, l1h_q, l2r_q, l2h_q;
	rsp_t rsp_q;
	logic out_valid_q;

	l1_line_t l1_mem [L1Sets][L1Ways];
	l2_line_t l2_mem [L2Sets][L2Ways];
	l1_line_t l1_rd_s1 [L1Ways];
	l2_line_t l2_rd_s1 [L2Ways];

	// Address split
	logic [L1SetBits-1:0] l1_set;
	logic [L2SetBits-1:0] l2_set;
	logic [L1TagBits-1:0] l1_tag;
	logic [L2TagBits-1:0] l2_tag;
	logic [L1SetBits-1:0] in_set1;
	assign l1_set = req_q.address[OffBits +: L1SetBits];
	assign l2_set = req_q.address[OffBits +: L2SetBits];
	assign l1_tag = req_q.address[63 -: L1TagBits];
	assign l2_tag = req_q.address[63 -: L2TagBits];
	assign in_set1 = in_data.address[OffBits +: L1SetBits];

	// L1 probe: hit way, first empty way, least stamp
	logic l1_hit;
	logic [1:0] l1_hw, l1_vw;
	always_comb begin
		logic have_e, have_l;
		logic [1:0] e, l;
		logic [31:0] ls;
		l1_hit = 1'b0; l1_hw = '0;
		have_e = 1'b0; have_l = 1'b0; e = '0; l = '0; ls = '0;
		for (int i = L1Ways - 1; i >= 0; i--) begin
			if (l1_rd_s1[i].v && l1_rd_s1[i].tag == l1_tag) begin
				l1_hit = 1'b1; l1_hw = 2'(i);
			end
		end
		for (int i = 0; i < L1Ways; i++) begin
			if (l1_rd_s1[i].v) begin
				if (!have_l || l1_rd_s1[i].use_stamp < ls) begin
					have_l = 1'b1; l = 2'(i); ls = l1_rd_s1[i].use_stamp;
				end
			end else if (!have_e) begin
				have_e = 1'b1; e = 2'(i);
			end
		end
		l1_vw = have_e ? e : l;
	end

	// L2 probe
	logic l2_hit;
	logic [2:0] l2_hw, l2_vw;
	always_comb begin
		logic have_e, have_l;
		logic [2:0] e, l;
		logic [31:0] ls;
		l2_hit = 1'b0; l2_hw = '0;
		have_e = 1'b0; have_l = 1'b0; e = '0; l = '0; ls = '0;
		for (int i = L2Ways - 1; i >= 0; i--) begin
			if (l2_rd_s1[i].v && l2_rd_s1[i].tag == l2_tag) begin
				l2_hit = 1'b1; l2_hw = 3'(i);
			end
		end
		for (int i = 0; i < L2Ways; i++) begin
			if (l2_rd_s1[i].v) begin
				if (!have_l || l2_rd_s1[i].use_stamp < ls) begin
					have_l = 1'b1; l = 3'(i); ls = l2_rd_s1[i].use_stamp;
				end
			end else if (!have_e) begin
				have_e = 1'b1; e = 3'(i);
			end
		end
		l2_vw = have_e ? e : l;
	end

	// Next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_CLEAR: if (clr_q == L2SetBits'(L2Sets - 1)) state_d = ST_IDLE;
			ST_IDLE:  if (in_valid) state_d = ST_L1;
			ST_L1:    state_d = l1_hit ? ST_OUT : ST_L2;
			ST_L2:    state_d = ST_OUT;
			ST_OUT:   if (out_ready) state_d = ST_IDLE;
			default:  state_d = ST_IDLE;
		endcase
	end

	// Handshake outputs
	always_comb begin
		in_ready = (state_q == ST_IDLE);
		cfg_ready = 1'b1;
	end
	assign out_valid = out_valid_q;
	assign out_data = rsp_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			clr_q <= '0;
			out_valid_q <= 1'b0;
			l1_lat_q <= 10'd1;
			l2_lat_q <= 10'd10;
			mem_lat_q <= 12'd100;
			sum_q <= '0; refs_q <= '0; l1h_q <= '0; l2r_q <= '0; l2h_q <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_CLEAR) clr_q <= clr_q + 1'b1;
			out_valid_q <= (state_d == ST_OUT);
			// take config writes
			if (cfg_valid) begin
				case (cfg_index)
					REG_L1_LAT:  l1_lat_q <= cfg_data[9:0];
					REG_L2_LAT:  l2_lat_q <= cfg_data[9:0];
					REG_MEM_LAT: mem_lat_q <= cfg_data[11:0];
					default: ;
				endcase
			end
			// advance counters when the result is formed
			if (state_q == ST_L1) begin
				refs_q <= refs_q + 1'b1;
				if (l1_hit) begin
					l1h_q <= l1h_q + 1'b1;
					sum_q <= sum_q + 32'(l1_lat_q);
				end else begin
					l2r_q <= l2r_q + 1'b1;
				end
			end
			if (state_q == ST_L2) begin
				if (l2_hit) begin
					l2h_q <= l2h_q + 1'b1;
					sum_q <= sum_q + 32'(l1_lat_q) + 32'(l2_lat_q);
				end else begin
					sum_q <= sum_q + 32'(l1_lat_q) + 32'(l2_lat_q) + 32'(mem_lat_q);
				end
			end
		end
	end

	// Capture the request
	always_ff @(posedge clk) begin
		if (in_valid && in_ready) req_q <= in_data;
	end

	// L1 RAM: clear in the clearing pass, read set on the input transfer, write back hit refresh or fill
	always_ff @(posedge clk) begin
		if (state_q == ST_CLEAR) begin
			if (clr_q < L2SetBits'(L1Sets))
				for (int i = 0; i < L1Ways; i++) l1_mem[clr_q[L1SetBits-1:0]][i] <= '0;
		end else if (state_q == ST_L1 && l1_hit) begin
			l1_mem[l1_set][l1_hw].use_stamp <= req_q.stamp;
			if (req_q.func == FUNC_WRITE) l1_mem[l1_set][l1_hw].d <= 1'b1;
		end else if (state_q == ST_L2) begin
			l1_mem[l1_set][l1_vw] <= '{v: 1'b1, d: 1'b0, use_stamp: req_q.stamp, tag: l1_tag};
		end
		if (in_valid && in_ready)
			for (int i = 0; i < L1Ways; i++) l1_rd_s1[i] <= l1_mem[in_set1][i];
	end

	// L2 RAM: clear in the clearing pass, read set during the L1 cycle, write back in the L2 cycle
	always_ff @(posedge clk) begin
		if (state_q == ST_CLEAR) begin
			for (int i = 0; i < L2Ways; i++) l2_mem[clr_q][i] <= '0;
		end else if (state_q == ST_L2) begin
			if (l2_hit) begin
				l2_mem[l2_set][l2_hw].use_stamp <= req_q.stamp;
				if (req_q.func == FUNC_WRITE) l2_mem[l2_set][l2_hw].d <= 1'b1;
			end else begin
				l2_mem[l2_set][l2_vw] <=
					'{v: 1'b1, d: 1'b0, use_stamp: req_q.stamp, tag: l2_tag};
			end
		end
		if (state_q == ST_L1)
			for (int i = 0; i < L2Ways; i++) l2_rd_s1[i] <= l2_mem[l2_set][i];
	end

	// Form the result
	always_ff @(posedge clk) begin
		if (state_q == ST_L1 && l1_hit) begin
			rsp_q.l1_hit <= 1'b1;
			rsp_q.l2_accessed <= 1'b0;
			rsp_q.l2_hit <= 1'b0;
			rsp_q.access_latency <= 13'(l1_lat_q);
			rsp_q.l1_dirty_evict <= 1'b0;
			rsp_q.l2_dirty_evict <= 1'b0;
			rsp_q.latency_total <= sum_q + 32'(l1_lat_q);
			rsp_q.reference_count <= refs_q + 1'b1;
			rsp_q.l1_hit_count <= l1h_q + 1'b1;
			rsp_q.l2_reference_count <= l2r_q;
			rsp_q.l2_hit_count <= l2h_q;
		end else if (state_q == ST_L2) begin
			rsp_q.l1_hit <= 1'b0;
			rsp_q.l2_accessed <= 1'b1;
			rsp_q.l2_hit <= l2_hit;
			rsp_q.l1_dirty_evict <= l1_rd_s1[l1_vw].v & l1_rd_s1[l1_vw].d;
			rsp_q.l2_dirty_evict <= !l2_hit && l2_rd_s1[l2_vw].v && l2_rd_s1[l2_vw].d;
			rsp_q.reference_count <= refs_q;
			rsp_q.l1_hit_count <= l1h_q;
			rsp_q.l2_reference_count <= l2r_q;
			if (l2_hit) begin
				rsp_q.access_latency <= 13'(l1_lat_q) + 13'(l2_lat_q);
				rsp_q.latency_total <= sum_q + 32'(l1_lat_q) + 32'(l2_lat_q);
				rsp_q.l2_hit_count <= l2h_q + 1'b1;
			end else begin
				rsp_q.access_latency <= 13'(l1_lat_q) + 13'(l2_lat_q) + 13'(mem_lat_q);
				rsp_q.latency_total <= sum_q + 32'(l1_lat_q) + 32'(l2_lat_q)
					+ 32'(mem_lat_q);
				rsp_q.l2_hit_count <= l2h_q;
			end
		end
	end

	`TLC_ASSERT_IMP(a_no_accept_in_clear, state_q == ST_CLEAR, !in_ready, "accept during clear")
	`TLC_ASSERT_NXT(a_hold_out, out_valid && !out_ready, out_valid, "result dropped")
	`TLC_ASSERT_IMP(a_ready_excl, in_ready, !out_valid, "input taken with result pending")
endmodule
